/* rtl/xml_byte_tokenizer_assert.svh */
// assertion macros for the tokenizer files, included by xbt_back
`ifndef XML_BYTE_TOKENIZER_ASSERT_SVH
`define XML_BYTE_TOKENIZER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define XBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xbt_pkg.sv */
package xbt_pkg;

  localparam int CNT_W   = 64;
  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 2;

  typedef enum logic [3:0] {
    K_PI          = 4'd0,
    K_COMMENT     = 4'd1,
    K_OPEN        = 4'd2,
    K_OPEN_SLASH  = 4'd3,
    K_CLOSE       = 4'd4,
    K_SLASH_CLOSE = 4'd5,
    K_NAME        = 4'd6,
    K_EQUALS      = 4'd7,
    K_VALUE       = 4'd8,
    K_REF         = 4'd9,
    K_CHARDATA    = 4'd10
  } tok_kind_e;

  typedef enum logic [2:0] {
    E_NONE      = 3'd0,
    E_UNTERM_PI = 3'd1,
    E_UNTERM_CM = 3'd2,
    E_BAD_CM    = 3'd3,
    E_BAD_VALUE = 3'd4
  } err_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LT, S_LT_BANG, S_LT_BANG_DASH, S_PI, S_PI_Q, S_CM, S_CM_D,
    S_CM_DD, S_SLASH, S_NAME, S_VALUE, S_REF, S_CDATA, S_HALT
  } scan_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } xbt_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } xbt_out_t;

  typedef struct packed {
    tok_kind_e        kind;
    logic [CNT_W-1:0] beg;
    logic [CNT_W-1:0] fin;
    err_e             err;
  } tok_rec_t;

  typedef struct packed {
    tok_rec_t [MAX_RES-1:0] rec;
    logic [2:0]             cnt;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

/* rtl/xbt_front.sv */
module xbt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  xbt_pkg::xbt_in_t in_data_i,
  input  xbt_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output xbt_pkg::bundle_t bundle_o
);
  import xbt_pkg::*;

  localparam logic [7:0] CH_LT = 8'h3C, CH_GT = 8'h3E, CH_SL = 8'h2F, CH_EQ = 8'h3D;
  localparam logic [7:0] CH_DQ = 8'h22, CH_SQ = 8'h27, CH_AMP = 8'h26, CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_QM = 8'h3F, CH_BANG = 8'h21, CH_DASH = 8'h2D;

  typedef struct packed {
    scan_e            st;
    logic             tag;
    logic [CNT_W-1:0] tb;
    logic [7:0]       qc;
    bundle_t          bun;
  } ctx_t;

  scan_e            st_q;
  logic             tag_q;
  logic [CNT_W-1:0] tb_q, pos_q;
  logic [7:0]       qc_q;
  logic             xfer;
  ctx_t             cur, nxt;

  function automatic logic is_ws(logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0D, 8'h0A};
  endfunction

  function automatic logic name_start(logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h3A, 8'h5F,
                     [8'hC0:8'hD6], [8'hD8:8'hF6], [8'hF8:8'hFF]};
  endfunction

  function automatic logic name_more(logic [7:0] b);
    return name_start(b) || (b inside {8'h2D, 8'h2E, [8'h30:8'h39], 8'hB7});
  endfunction

  function automatic ctx_t add_tok(ctx_t c, tok_kind_e k, logic [CNT_W-1:0] bg,
                                   logic [CNT_W-1:0] fn, err_e e);
    ctx_t r;
    r = c;
    if (r.bun.cnt < 3'(MAX_RES)) begin
      r.bun.rec[r.bun.cnt[1:0]] = '{kind: k, beg: bg, fin: fn, err: e};
      r.bun.cnt = r.bun.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic ctx_t start_tok(ctx_t c, logic [7:0] b, logic [CNT_W-1:0] p);
    ctx_t r;
    r = c;
    r.st = S_IDLE;
    if (!(r.tag && is_ws(b))) begin
      r.tb = p;
      if (b == CH_LT) r.st = S_LT;
      else if (b == CH_GT) begin
        r = add_tok(r, K_CLOSE, p, p + 1, E_NONE);
        r.tag = 1'b0;
      end else if (b == CH_SL) r.st = S_SLASH;
      else if (r.tag && name_start(b)) r.st = S_NAME;
      else if (r.tag && b == CH_EQ) r = add_tok(r, K_EQUALS, p, p + 1, E_NONE);
      else if (r.tag && (b == CH_DQ || b == CH_SQ)) begin
        r.qc = b;
        r.tb = p + 1;
        r.st = S_VALUE;
      end else if (b == CH_AMP) r.st = S_REF;
      else r.st = S_CDATA;
    end
    return r;
  endfunction

  function automatic ctx_t cdata_next(ctx_t c, logic [7:0] b, logic [CNT_W-1:0] p);
    ctx_t r;
    r = c;
    if (b == CH_LT || b == CH_AMP) begin
      r = add_tok(r, K_CHARDATA, r.tb, p, E_NONE);
      r = start_tok(r, b, p);
    end
    return r;
  endfunction

  // "<!" or "<!-" cut short: open tag, then the held '!' starts character data
  function automatic ctx_t open_bang(ctx_t c);
    ctx_t r;
    r = add_tok(c, K_OPEN, c.tb, c.tb + 1, E_NONE);
    r.tag = 1'b1;
    r.tb  = c.tb + 1;
    r.st  = S_CDATA;
    return r;
  endfunction

  function automatic ctx_t take(ctx_t c, logic [7:0] b, logic [CNT_W-1:0] p);
    ctx_t r;
    r = c;
    case (c.st)
      S_LT: begin
        if (b == CH_QM) r.st = S_PI;
        else if (b == CH_SL) begin
          r = add_tok(r, K_OPEN_SLASH, r.tb, p + 1, E_NONE);
          r.tag = 1'b1;
          r.st  = S_IDLE;
        end else if (b == CH_BANG) r.st = S_LT_BANG;
        else begin
          r = add_tok(r, K_OPEN, r.tb, r.tb + 1, E_NONE);
          r.tag = 1'b1;
          r = start_tok(r, b, p);
        end
      end
      S_LT_BANG: begin
        if (b == CH_DASH) r.st = S_LT_BANG_DASH;
        else r = cdata_next(open_bang(r), b, p);
      end
      S_LT_BANG_DASH: begin
        if (b == CH_DASH) r.st = S_CM;
        else r = cdata_next(open_bang(r), b, p);
      end
      S_PI: if (b == CH_QM) r.st = S_PI_Q;
      S_PI_Q: begin
        if (b == CH_GT) begin
          r = add_tok(r, K_PI, r.tb, p + 1, E_NONE);
          r.st = S_IDLE;
        end else if (b != CH_QM) r.st = S_PI;
      end
      S_CM: if (b == CH_DASH) r.st = S_CM_D;
      S_CM_D: r.st = (b == CH_DASH) ? S_CM_DD : S_CM;
      S_CM_DD: begin
        if (b == CH_GT) begin
          r = add_tok(r, K_COMMENT, r.tb, p + 1, E_NONE);
          r.st = S_IDLE;
        end else begin
          r = add_tok(r, K_COMMENT, r.tb, p, E_BAD_CM);
          r.st = S_HALT;
        end
      end
      S_SLASH: begin
        if (b == CH_GT) begin
          r = add_tok(r, K_SLASH_CLOSE, r.tb, p + 1, E_NONE);
          r.tag = 1'b0;
          r.st  = S_IDLE;
        end else begin
          r.st = S_CDATA;
          r = cdata_next(r, b, p);
        end
      end
      S_NAME: begin
        if (!name_more(b)) begin
          r = add_tok(r, K_NAME, r.tb, p, E_NONE);
          r = start_tok(r, b, p);
        end
      end
      S_VALUE: begin
        if (b == CH_LT || b == CH_AMP) begin
          r = add_tok(r, K_VALUE, r.tb, p, E_BAD_VALUE);
          r.st = S_HALT;
        end else if (b == r.qc) begin
          r = add_tok(r, K_VALUE, r.tb, p, E_NONE);
          r.st = S_IDLE;
        end
      end
      S_REF: begin
        if (b == CH_SEMI) begin
          r = add_tok(r, K_REF, r.tb, p + 1, E_NONE);
          r.st = S_IDLE;
        end
      end
      S_CDATA: r = cdata_next(r, b, p);
      S_HALT: r = c;
      default: r = start_tok(r, b, p);
    endcase
    return r;
  endfunction

  function automatic ctx_t flush(ctx_t c, logic [CNT_W-1:0] e);
    ctx_t r;
    r = c;
    if (r.st == S_LT) begin
      r = add_tok(r, K_OPEN, r.tb, r.tb + 1, E_NONE);
      r.tag = 1'b1;
      r.st  = S_IDLE;
    end else if (r.st == S_LT_BANG || r.st == S_LT_BANG_DASH) begin
      r = open_bang(r);
    end
    case (r.st)
      S_PI, S_PI_Q:     r = add_tok(r, K_PI, r.tb, e, E_UNTERM_PI);
      S_CM, S_CM_D:     r = add_tok(r, K_COMMENT, r.tb, e, E_UNTERM_CM);
      S_CM_DD:          r = add_tok(r, K_COMMENT, r.tb, e, E_BAD_CM);
      S_SLASH, S_CDATA: r = add_tok(r, K_CHARDATA, r.tb, e, E_NONE);
      S_NAME:           r = add_tok(r, K_NAME, r.tb, e, E_NONE);
      S_VALUE:          r = add_tok(r, K_VALUE, r.tb, e, E_NONE);
      S_REF:            r = add_tok(r, K_REF, r.tb, e, E_NONE);
      default:          r = r;
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_stat_i.full;
  assign xfer       = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    cur = '{st: st_q, tag: tag_q, tb: tb_q, qc: qc_q, bun: '0};
    nxt = take(cur, in_data_i.in_byte, pos_q);
    if (in_data_i.end_of_text) nxt = flush(nxt, pos_q + 1);
  end

  // outputs
  always_comb begin
    bundle_o = nxt.bun;
    push_o   = xfer && (nxt.bun.cnt != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      tag_q <= 1'b0;
      tb_q  <= '0;
      qc_q  <= '0;
      pos_q <= '0;
    end else if (xfer) begin
      if (in_data_i.end_of_text) begin
        st_q  <= S_IDLE;
        tag_q <= 1'b0;
        tb_q  <= '0;
        qc_q  <= '0;
        pos_q <= '0;
      end else begin
        st_q  <= nxt.st;
        tag_q <= nxt.tag;
        tb_q  <= nxt.tb;
        qc_q  <= nxt.qc;
        pos_q <= pos_q + 1;
      end
    end
  end

endmodule

/* rtl/xbt_queue.sv */
module xbt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xbt_pkg::bundle_t data_i,
  input  logic             pop_i,
  output xbt_pkg::q_stat_t stat_o,
  output xbt_pkg::bundle_t data_o
);
  import xbt_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  bundle_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]    wr_q, rd_q;
  logic [CNT_QW-1:0]   cnt_q;

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] v);
    return (v == PTR_W'(QDEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CNT_QW'(QDEPTH));
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i) rd_q <= inc(rd_q);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/xbt_back.sv */
module xbt_back #(
  parameter int POS_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xbt_pkg::q_stat_t  q_stat_i,
  input  xbt_pkg::bundle_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xbt_pkg::xbt_out_t out_data_o
);
  import xbt_pkg::*;

  localparam logic [CNT_W-1:0] POS_MASK = {CNT_W{1'b1}} >> (CNT_W - POS_WIDTH);

  logic [1:0]       idx_q;
  logic             valid_q;
  xbt_out_t         out_q;
  logic             load, last;
  tok_rec_t         rec;
  logic [CNT_W-1:0] diff;

  assign rec   = head_i.rec[idx_q];
  assign diff  = rec.fin - rec.beg;
  assign last  = ({1'b0, idx_q} == head_i.cnt - 3'd1);
  assign load  = q_stat_i.valid && (!valid_q || out_ready_i);
  assign pop_o = load && last;

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.token_kind   <= 4'(rec.kind);
      out_q.token_start  <= 32'(rec.beg & POS_MASK);
      out_q.token_length <= (|diff[CNT_W-1:32]) ? 32'hFFFF_FFFF : diff[31:0];
      out_q.error_code   <= 3'(rec.err);
      out_q.last_of_run  <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= last ? 2'd0 : idx_q + 2'd1;
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  `include "xml_byte_tokenizer_assert.svh"

  `XBT_ASSERT_NXT(a_idx_wraps, pop_o, idx_q == 2'd0, "record index not back at zero")
  `XBT_ASSERT_IMP(a_idx_in_range, q_stat_i.valid, {1'b0, idx_q} < head_i.cnt, "index past count")
  `XBT_ASSERT_IMP(a_err_kind, valid_q && out_q.error_code != 3'(E_NONE),
    out_q.token_kind == 4'(K_PI) || out_q.token_kind == 4'(K_COMMENT) ||
    out_q.token_kind == 4'(K_VALUE), "error on a token kind that cannot fail")

endmodule

/* rtl/xml_byte_tokenizer.sv */
// path: a transferred byte's tokens go into the queue, then into the output register
// throughput: one byte per cycle in while the queue is not full, one token per cycle out
// while out_ready_i is high; a byte's tokens leave one after another, a two-entry queue absorbs bursts
// reset: asynchronous active-low clears scanner state, position, queue and output
// end_of_text flushes the pending token and returns the scanner to reset state
module xml_byte_tokenizer #(
  parameter int POS_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xbt_pkg::xbt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xbt_pkg::xbt_out_t out_data_o
);
  import xbt_pkg::*;

  // front: scanner classifies each transferred byte into a bundle of tokens
  logic    push, pop;
  bundle_t push_bun, head_bun;
  q_stat_t q_stat;

  xbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .bundle_o   (push_bun)
  );

  // queue of token bundles decouples scanner from output
  xbt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_bun),
    .pop_i  (pop),
    .stat_o (q_stat),
    .data_o (head_bun)
  );

  // back: serializes each bundle, computes length, holds output register
  xbt_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head_bun),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
